>>> hdl/rbpc_pkg.sv
package rbpc_pkg;

    localparam int MAX_CHANNELS_DEF = 32;
    localparam int PULSE_SLOTS_DEF  = 16;

    localparam int ACTION_W = 2;
    localparam int CH_W     = 5;
    localparam int OP_W     = 2;
    localparam int TIME_W   = 32;
    localparam int SEQ_W    = 16;
    localparam int MASK_W   = 32;
    localparam int CNT_W    = 6;

    localparam logic [ACTION_W-1:0] ACT_COMMAND = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_QUERY   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd2;

    localparam logic [OP_W-1:0] OP_OFF    = 2'd0;
    localparam logic [OP_W-1:0] OP_ON     = 2'd1;
    localparam logic [OP_W-1:0] OP_TOGGLE = 2'd2;
    localparam logic [OP_W-1:0] OP_BAD    = 2'd3;

    typedef struct packed {
        logic              valid;
        logic              alloc;
        logic [MASK_W-1:0] clear_mask;
    } rbpc_link_t;

    typedef struct packed {
        logic              tick;
        logic [CH_W-1:0]   channel;
        logic [TIME_W-1:0] stamp;
    } rbpc_bcast_t;

    typedef struct packed {
        logic              reply_valid;
        logic [SEQ_W-1:0]  reply_seq;
        logic [MASK_W-1:0] relay_mask;
        logic [CNT_W-1:0]  reported_count;
        logic              pulse_dropped;
    } rbpc_rsp_t;

endpackage

>>> hdl/rbpc_ifs.sv
interface rbpc_cmd_if import rbpc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [CH_W-1:0]     channel;
    logic [OP_W-1:0]     op;
    logic [TIME_W-1:0]   pulse_len_ms;
    logic [TIME_W-1:0]   now_ms;
    logic [SEQ_W-1:0]    request_seq;

    modport source (output valid, action, channel, op, pulse_len_ms, now_ms, request_seq,
                    input ready);
    modport sink   (input valid, action, channel, op, pulse_len_ms, now_ms, request_seq,
                    output ready);
endinterface

interface rbpc_rsp_if import rbpc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              reply_valid;
    logic [SEQ_W-1:0]  reply_seq;
    logic [MASK_W-1:0] relay_mask;
    logic [CNT_W-1:0]  reported_count;
    logic              pulse_dropped;

    modport source (output valid, reply_valid, reply_seq, relay_mask, reported_count,
                    pulse_dropped, input ready);
    modport sink   (input valid, reply_valid, reply_seq, relay_mask, reported_count,
                    pulse_dropped, output ready);
endinterface

interface rbpc_cfg_if import rbpc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] channel_count;

    modport source (output valid, channel_count, input ready);
    modport sink   (input valid, channel_count, output ready);
endinterface

>>> hdl/rbpc_cell.sv
module rbpc_cell import rbpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  rbpc_bcast_t bcast,
    input  rbpc_link_t  link_in,
    output rbpc_link_t  link_out
);

    logic              used_reg;
    logic              used_next;
    logic [CH_W-1:0]   chan_reg;
    logic [TIME_W-1:0] time_reg;
    rbpc_link_t        link_reg;
    rbpc_link_t        link_next;
    logic              expire;
    logic              take;

    always_comb
    begin
        expire    = link_in.valid && bcast.tick && used_reg && (time_reg <= bcast.stamp);
        take      = link_in.valid && !bcast.tick && link_in.alloc && !used_reg;
        used_next = used_reg;
        link_next = link_in;
        if (expire)
        begin
            used_next            = 1'b0;
            link_next.clear_mask = link_in.clear_mask | (MASK_W'(1) << chan_reg);
        end
        if (take)
        begin
            used_next       = 1'b1;
            link_next.alloc = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            link_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
            link_reg <= link_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            chan_reg <= bcast.channel;
            time_reg <= bcast.stamp;
        end
    end

    assign link_out = link_reg;

endmodule

>>> hdl/relay_bank_pulse_controller_top.sv
// channel  modport  role
// -------  -------  ---------------------------------------------------------
// cmd      sink     command, query or tick item in
// rsp      source   one result item out per accepted item
// cfg      sink     channel_count write, always ready
//
// Flow: the item token walks the row of slot cells one cell per clock, and the
// next item enters after it leaves.
// Reset: relays off, all slots free, channel_count 32.
// Stalls: a finished result waits in the output register and a hold register;
// the next item is taken while the output waits, not while the hold is full.
module relay_bank_pulse_controller_top import rbpc_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int PULSE_SLOTS  = PULSE_SLOTS_DEF
)
(
    input logic    clk,
    input logic    rst_n,
    rbpc_cmd_if.sink   cmd,
    rbpc_rsp_if.source rsp,
    rbpc_cfg_if.sink   cfg
);

    logic [CNT_W-1:0]  cc_reg;
    logic [MASK_W-1:0] relay_reg;
    logic [MASK_W-1:0] relay_next;
    logic              busy_reg;
    logic              busy_next;
    rbpc_link_t        head_reg;
    rbpc_link_t        head_next;
    rbpc_bcast_t       bcast_reg;
    rbpc_rsp_t         res_reg;
    rbpc_rsp_t         res_next;
    rbpc_rsp_t         out_reg;
    rbpc_rsp_t         out_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    rbpc_rsp_t         hold_reg;
    rbpc_rsp_t         hold_next;
    logic              hold_valid_reg;
    logic              hold_valid_next;

    rbpc_link_t        link [0:PULSE_SLOTS];
    logic [PULSE_SLOTS:0] chain_valid;

    logic              accept;
    logic              out_take;
    logic              done;
    logic [CNT_W-1:0]  eff;
    logic [MASK_W-1:0] low_mask;
    logic              cmd_ok;
    logic              want_pulse;
    logic [MASK_W-1:0] bit_sel;
    logic [MASK_W-1:0] relay_cmd;
    rbpc_rsp_t         fin;

    assign accept   = cmd.valid && cmd.ready;
    assign cmd.ready = !busy_reg && !hold_valid_reg;
    assign cfg.ready = 1'b1;
    assign out_take = out_valid_reg && rsp.ready;

    assign eff      = (cc_reg > CNT_W'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS) : cc_reg;
    assign low_mask = (eff >= CNT_W'(MASK_W)) ? {MASK_W{1'b1}}
                                              : ((MASK_W'(1) << eff) - MASK_W'(1));
    assign bit_sel  = MASK_W'(1) << cmd.channel;
    assign cmd_ok   = (cmd.action == ACT_COMMAND) && ({1'b0, cmd.channel} < eff)
                      && (cmd.op != OP_BAD);
    assign want_pulse = cmd_ok && (cmd.pulse_len_ms != '0) && (cmd.op != OP_OFF);

    always_comb
    begin
        case (cmd.op)
            OP_OFF:    relay_cmd = relay_reg & ~bit_sel;
            OP_ON:     relay_cmd = relay_reg | bit_sel;
            OP_TOGGLE: relay_cmd = relay_reg ^ bit_sel;
            default:   relay_cmd = relay_reg;
        endcase
        if (want_pulse)
        begin
            relay_cmd = relay_cmd | bit_sel;
        end
    end

    assign link[0] = head_reg;

    genvar gi;
    generate
        for (gi = 0; gi < PULSE_SLOTS; gi++)
        begin : g_cell
            rbpc_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .bcast    (bcast_reg),
                .link_in  (link[gi]),
                .link_out (link[gi+1])
            );
        end
        for (gi = 0; gi <= PULSE_SLOTS; gi++)
        begin : g_valid
            assign chain_valid[gi] = link[gi].valid;
        end
    endgenerate

    assign done = link[PULSE_SLOTS].valid;

    always_comb
    begin
        fin               = res_reg;
        fin.pulse_dropped = link[PULSE_SLOTS].alloc;

        relay_next = relay_reg;
        busy_next  = busy_reg;
        res_next   = res_reg;
        head_next  = '0;

        if (accept)
        begin
            busy_next       = 1'b1;
            head_next.valid = 1'b1;
            head_next.alloc = want_pulse;
            res_next        = '0;
            if (cmd_ok)
            begin
                relay_next              = relay_cmd;
                res_next.reply_valid    = 1'b1;
                res_next.reply_seq      = cmd.request_seq;
                res_next.relay_mask     = relay_cmd & low_mask;
                res_next.reported_count = eff;
            end
            else if (cmd.action == ACT_QUERY)
            begin
                res_next.reply_valid    = 1'b1;
                res_next.reply_seq      = cmd.request_seq;
                res_next.relay_mask     = relay_reg & low_mask;
                res_next.reported_count = eff;
            end
        end

        if (done)
        begin
            busy_next  = 1'b0;
            relay_next = relay_reg & ~link[PULSE_SLOTS].clear_mask;
        end

        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        if (done)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_next       = fin;
                out_valid_next = 1'b1;
            end
            else
            begin
                hold_next       = fin;
                hold_valid_next = 1'b1;
            end
        end
        else if (out_take)
        begin
            if (hold_valid_reg)
            begin
                out_next        = hold_reg;
                hold_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg         <= CNT_W'(32);
            relay_reg      <= '0;
            busy_reg       <= 1'b0;
            head_reg       <= '0;
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                cc_reg <= cfg.channel_count;
            end
            relay_reg      <= relay_next;
            busy_reg       <= busy_next;
            head_reg       <= head_next;
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bcast_reg.tick    <= (cmd.action == ACT_TICK);
            bcast_reg.channel <= cmd.channel;
            bcast_reg.stamp   <= (cmd.action == ACT_TICK) ? cmd.now_ms
                                                          : cmd.now_ms + cmd.pulse_len_ms;
        end
        res_reg  <= res_next;
        out_reg  <= out_next;
        hold_reg <= hold_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.reply_valid    = out_reg.reply_valid;
    assign rsp.reply_seq      = out_reg.reply_seq;
    assign rsp.relay_mask     = out_reg.relay_mask;
    assign rsp.reported_count = out_reg.reported_count;
    assign rsp.pulse_dropped  = out_reg.pulse_dropped;

    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(chain_valid))
        else $error("more than one item token in the slot chain");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg && head_reg.valid)
        else $error("accepted item did not enter the slot chain");

    a_token_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy_reg)
        else $error("chain token left while idle");

    a_hold_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> out_valid_reg)
        else $error("hold register full with output register empty");

endmodule
